>>> rtl/adc_pkg.sv
`timescale 1ns / 1ps
// adc_pkg: shared types, codes and character-class helpers for the ADC message parser.
// No dependencies.
package adc_pkg;

    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        PH_HEAD   = 3'd0,
        PH_SPACE  = 3'd1,
        PH_FIRST  = 3'd2,
        PH_SECOND = 3'd3,
        PH_PARAM  = 3'd4
    } phase_t;

    localparam logic [2:0] ROLE_SRC_SID = 3'd0;
    localparam logic [2:0] ROLE_TGT_SID = 3'd1;
    localparam logic [2:0] ROLE_FEATURE = 3'd2;
    localparam logic [2:0] ROLE_SRC_CID = 3'd3;
    localparam logic [2:0] ROLE_PARAM   = 3'd4;

    localparam logic [2:0] HDR_B = 3'd0;
    localparam logic [2:0] HDR_C = 3'd1;
    localparam logic [2:0] HDR_D = 3'd2;
    localparam logic [2:0] HDR_E = 3'd3;
    localparam logic [2:0] HDR_F = 3'd4;
    localparam logic [2:0] HDR_H = 3'd5;
    localparam logic [2:0] HDR_I = 3'd6;
    localparam logic [2:0] HDR_U = 3'd7;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;
    localparam logic [3:0] CMD_UNKNOWN  = 4'd15;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] role;
        logic [7:0] parameter_index;
        logic [7:0] payload_byte;
        logic [2:0] header_code;
        logic [3:0] command_code;
        logic [1:0] status;
        logic       last_result;
    } result_t;

    // one accepted word worth of results: optional payload, optional verdict
    typedef struct packed {
        logic    pay_valid;
        result_t pay;
        logic    ver_valid;
        result_t ver;
    } entry_t;

    function automatic logic is_up(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_an(input logic [7:0] c);
        return is_up(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    function automatic logic is_b32(input logic [7:0] c);
        return is_up(c) || ((c >= 8'h32) && (c <= 8'h37));
    endfunction

    // header letter to code; bit 3 set when the letter is not a header
    function automatic logic [3:0] head_code(input logic [7:0] c);
        logic [3:0] r;
        unique case (c)
            8'h42:   r = {1'b0, HDR_B};
            8'h43:   r = {1'b0, HDR_C};
            8'h44:   r = {1'b0, HDR_D};
            8'h45:   r = {1'b0, HDR_E};
            8'h46:   r = {1'b0, HDR_F};
            8'h48:   r = {1'b0, HDR_H};
            8'h49:   r = {1'b0, HDR_I};
            8'h55:   r = {1'b0, HDR_U};
            default: r = 4'b1000;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] cmd_code(input logic [23:0] l);
        logic [3:0] r;
        unique case (l)
            24'h535441: r = 4'd0;   // STA
            24'h535550: r = 4'd1;   // SUP
            24'h534944: r = 4'd2;   // SID
            24'h494E46: r = 4'd3;   // INF
            24'h4D5347: r = 4'd4;   // MSG
            24'h534348: r = 4'd5;   // SCH
            24'h524553: r = 4'd6;   // RES
            24'h43544D: r = 4'd7;   // CTM
            24'h52434D: r = 4'd8;   // RCM
            24'h515549: r = 4'd9;   // QUI
            24'h475041: r = 4'd10;  // GPA
            24'h504153: r = 4'd11;  // PAS
            24'h474554: r = 4'd12;  // GET
            24'h474649: r = 4'd13;  // GFI
            24'h534E44: r = 4'd14;  // SND
            default:    r = CMD_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/adc_if.sv
`timescale 1ns / 1ps
// adc_in_if / adc_out_if: valid/ready channels for message bytes and parse results.
// No dependencies.
interface adc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, byte_value, has_byte, end_of_message, input ready);
    modport sink   (input valid, byte_value, has_byte, end_of_message, output ready);
endinterface

interface adc_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [2:0] role;
    logic [7:0] parameter_index;
    logic [7:0] payload_byte;
    logic [2:0] header_code;
    logic [3:0] command_code;
    logic [1:0] status;
    logic       last_result;
    modport source (output valid, result_kind, role, parameter_index, payload_byte,
                    header_code, command_code, status, last_result, input ready);
    modport sink   (input valid, result_kind, role, parameter_index, payload_byte,
                    header_code, command_code, status, last_result, output ready);
endinterface

>>> rtl/adc_front.sv
`timescale 1ns / 1ps
// adc_front: per-byte syntax checker; turns each accepted word into a queue entry.
// Depends on adc_pkg and adc_if.
module adc_front (
    input  logic            clk,
    input  logic            rst_n,
    adc_in_if.sink          din,
    input  logic            q_full,
    output logic            q_push,
    output adc_pkg::entry_t q_entry
);
    import adc_pkg::*;

    phase_t      phase_reg, phase_next, p_phase;
    logic [7:0]  tok_reg, tok_next, p_tok;
    logic [2:0]  chars_reg, chars_next, p_chars;
    logic        esc_reg, esc_next, p_esc;
    logic        sep_reg, sep_next, p_sep;
    logic [2:0]  hdr_reg, hdr_next, p_hdr;
    logic [23:0] cmd_reg, cmd_next, p_cmd;
    logic        err_reg, err_next, p_err;

    logic [7:0]  b;
    logic        sp, fire, feed;
    logic        f_err, f_emit;
    logic [2:0]  f_role;
    logic [7:0]  f_byte;
    logic [3:0]  hc;
    logic [1:0]  verdict;

    function automatic logic tok_ok(input phase_t ph, input logic [2:0] h,
                                    input logic [2:0] n, input logic e);
        logic r;
        if (ph == PH_FIRST)
            r = (h == HDR_U) || (n == 3'd4);
        else if (ph == PH_SECOND)
            r = (h == HDR_F) ? (n == 3'd0) : (n == 3'd4);
        else
            r = !e;
        return r;
    endfunction

    assign b         = din.byte_value;
    assign sp        = (b == 8'h20);
    assign hc        = head_code(b);
    assign din.ready = !q_full;
    assign fire      = din.valid && din.ready;
    assign feed      = din.has_byte && !err_reg;

    // classify the byte against the current phase
    always_comb
    begin
        f_err  = 1'b0;
        f_emit = 1'b0;
        f_role = ROLE_PARAM;
        f_byte = b;
        unique case (phase_reg)
            PH_HEAD:
            begin
                if (chars_reg == 3'd0)
                    f_err = hc[3];
                else if (chars_reg == 3'd1)
                    f_err = !is_up(b);
                else
                    f_err = !is_an(b);
            end
            PH_SPACE:
                f_err = !sp;
            PH_FIRST, PH_SECOND, PH_PARAM:
            begin
                if (sp)
                    f_err = sep_reg || !tok_ok(phase_reg, hdr_reg, chars_reg, esc_reg);
                else if (phase_reg == PH_FIRST)
                begin
                    if (!is_b32(b))
                        f_err = 1'b1;
                    else if (hdr_reg == HDR_U)
                    begin
                        f_emit = 1'b1;
                        f_role = ROLE_SRC_CID;
                    end
                    else if (chars_reg >= 3'd4)
                        f_err = 1'b1;
                    else
                    begin
                        f_emit = 1'b1;
                        f_role = ROLE_SRC_SID;
                    end
                end
                else if (phase_reg == PH_SECOND)
                begin
                    f_role = (hdr_reg == HDR_F) ? ROLE_FEATURE : ROLE_TGT_SID;
                    if (hdr_reg == HDR_F)
                    begin
                        if (chars_reg == 3'd0)
                            f_err = !(b == 8'h2B || b == 8'h2D);
                        else if (chars_reg == 3'd1)
                            f_err = !is_up(b);
                        else
                            f_err = !is_an(b);
                    end
                    else
                        f_err = !is_b32(b) || (chars_reg >= 3'd4);
                    f_emit = !f_err;
                end
                else if (esc_reg)
                begin
                    unique case (b)
                        8'h73:   f_byte = 8'h20;
                        8'h6E:   f_byte = 8'h0A;
                        8'h5C:   f_byte = 8'h5C;
                        default: f_err  = 1'b1;
                    endcase
                    f_emit = !f_err;
                end
                else if (b == 8'h5C)
                    f_emit = 1'b0;
                else if (b == 8'h0A || b == 8'h0D)
                    f_err = 1'b1;
                else
                    f_emit = 1'b1;
            end
            default:
                f_err = 1'b1;
        endcase
    end

    // state after the byte, then reset on end of message
    always_comb
    begin
        p_phase = phase_reg;
        p_tok   = tok_reg;
        p_chars = chars_reg;
        p_esc   = esc_reg;
        p_sep   = sep_reg;
        p_hdr   = hdr_reg;
        p_cmd   = cmd_reg;
        p_err   = err_reg;
        if (feed)
        begin
            if (f_err)
                p_err = 1'b1;
            else
            begin
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        if (chars_reg == 3'd0)
                            p_hdr = hc[2:0];
                        else
                            p_cmd = {cmd_reg[15:0], b};
                        if (chars_reg == 3'd3)
                        begin
                            p_phase = PH_SPACE;
                            p_chars = 3'd0;
                        end
                        else
                            p_chars = chars_reg + 3'd1;
                    end
                    PH_SPACE:
                    begin
                        p_phase = (hdr_reg == HDR_C || hdr_reg == HDR_H || hdr_reg == HDR_I)
                                  ? PH_PARAM : PH_FIRST;
                        p_sep   = 1'b1;
                        p_chars = 3'd0;
                    end
                    PH_FIRST, PH_SECOND, PH_PARAM:
                    begin
                        if (sp)
                        begin
                            if (phase_reg == PH_FIRST)
                                p_phase = (hdr_reg == HDR_D || hdr_reg == HDR_E ||
                                           hdr_reg == HDR_F) ? PH_SECOND : PH_PARAM;
                            else if (phase_reg == PH_SECOND)
                                p_phase = PH_PARAM;
                            else if (tok_reg != 8'hFF)
                                p_tok = tok_reg + 8'd1;
                            p_sep   = 1'b1;
                            p_chars = 3'd0;
                        end
                        else
                        begin
                            p_sep = 1'b0;
                            if (phase_reg == PH_FIRST)
                            begin
                                if (hdr_reg != HDR_U)
                                    p_chars = chars_reg + 3'd1;
                            end
                            else if (phase_reg == PH_SECOND)
                            begin
                                if (hdr_reg == HDR_F && chars_reg >= 3'd4)
                                    p_chars = 3'd0;
                                else
                                    p_chars = chars_reg + 3'd1;
                            end
                            else if (esc_reg)
                                p_esc = 1'b0;
                            else if (b == 8'h5C)
                                p_esc = 1'b1;
                        end
                    end
                    default:
                        p_err = 1'b1;
                endcase
            end
        end
    end

    always_comb
    begin
        if (!p_err && p_phase == PH_HEAD && p_chars == 3'd0)
            verdict = ST_EMPTY;
        else if (p_err || p_phase == PH_HEAD)
            verdict = ST_INVALID;
        else if (p_phase == PH_SPACE)
            verdict = (p_hdr == HDR_C || p_hdr == HDR_H || p_hdr == HDR_I)
                      ? ST_VALID : ST_INVALID;
        else if (p_sep || !tok_ok(p_phase, p_hdr, p_chars, p_esc))
            verdict = ST_INVALID;
        else if (p_phase == PH_FIRST &&
                 (p_hdr == HDR_D || p_hdr == HDR_E || p_hdr == HDR_F))
            verdict = ST_INVALID;
        else
            verdict = ST_VALID;
    end

    always_comb
    begin
        if (fire && din.end_of_message)
        begin
            phase_next = PH_HEAD;
            tok_next   = 8'd0;
            chars_next = 3'd0;
            esc_next   = 1'b0;
            sep_next   = 1'b0;
            hdr_next   = 3'd0;
            cmd_next   = 24'd0;
            err_next   = 1'b0;
        end
        else if (fire)
        begin
            phase_next = p_phase;
            tok_next   = p_tok;
            chars_next = p_chars;
            esc_next   = p_esc;
            sep_next   = p_sep;
            hdr_next   = p_hdr;
            cmd_next   = p_cmd;
            err_next   = p_err;
        end
        else
        begin
            phase_next = phase_reg;
            tok_next   = tok_reg;
            chars_next = chars_reg;
            esc_next   = esc_reg;
            sep_next   = sep_reg;
            hdr_next   = hdr_reg;
            cmd_next   = cmd_reg;
            err_next   = err_reg;
        end
    end

    always_comb
    begin
        q_entry.pay_valid           = feed && !f_err && f_emit;
        q_entry.pay.result_kind     = KIND_PAYLOAD;
        q_entry.pay.role            = f_role;
        q_entry.pay.parameter_index = (f_role == ROLE_PARAM) ? tok_reg : 8'd0;
        q_entry.pay.payload_byte    = f_byte;
        q_entry.pay.header_code     = hdr_reg;
        q_entry.pay.command_code    = cmd_code(cmd_reg);
        q_entry.pay.status          = ST_VALID;
        q_entry.pay.last_result     = !din.end_of_message;
        q_entry.ver_valid           = din.end_of_message;
        q_entry.ver.result_kind     = KIND_VERDICT;
        q_entry.ver.role            = ROLE_SRC_SID;
        q_entry.ver.parameter_index = 8'd0;
        q_entry.ver.payload_byte    = 8'd0;
        q_entry.ver.header_code     = (verdict == ST_VALID) ? p_hdr : 3'd0;
        q_entry.ver.command_code    = (verdict == ST_VALID) ? cmd_code(p_cmd) : CMD_UNKNOWN;
        q_entry.ver.status          = verdict;
        q_entry.ver.last_result     = 1'b1;
        q_push = fire && (q_entry.pay_valid || q_entry.ver_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            tok_reg   <= 8'd0;
            chars_reg <= 3'd0;
            esc_reg   <= 1'b0;
            sep_reg   <= 1'b0;
            hdr_reg   <= 3'd0;
            cmd_reg   <= 24'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tok_reg   <= tok_next;
            chars_reg <= chars_next;
            esc_reg   <= esc_next;
            sep_reg   <= sep_next;
            hdr_reg   <= hdr_next;
            cmd_reg   <= cmd_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> rtl/adc_queue.sv
`timescale 1ns / 1ps
// adc_queue: small FIFO of entries between the checker and the result sequencer.
// Depends on adc_pkg.
module adc_queue #(
    parameter int DEPTH = adc_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  adc_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output adc_pkg::entry_t head
);
    import adc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head     = mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/adc_back.sv
`timescale 1ns / 1ps
// adc_back: output register; sends the payload then the verdict of each entry.
// Depends on adc_pkg and adc_if.
module adc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_nonempty,
    input  adc_pkg::entry_t q_head,
    output logic            q_pop,
    adc_out_if.source       dout
);
    import adc_pkg::*;

    entry_t  cur_reg, cur_next;
    logic    busy_reg, busy_next;
    logic    on_pay;
    logic    take, done;
    result_t r;

    assign on_pay = cur_reg.pay_valid;
    assign r      = on_pay ? cur_reg.pay : cur_reg.ver;
    assign take   = dout.valid && dout.ready;
    // entry finished when the word shown is its last one
    assign done   = take && !(on_pay && cur_reg.ver_valid);
    assign q_pop  = q_nonempty && (!busy_reg || done);

    always_comb
    begin
        cur_next  = cur_reg;
        busy_next = busy_reg;
        if (take && !done)
            cur_next.pay_valid = 1'b0;
        if (q_pop)
        begin
            cur_next  = q_head;
            busy_next = 1'b1;
        end
        else if (done)
            busy_next = 1'b0;
    end

    assign dout.valid           = busy_reg;
    assign dout.result_kind     = r.result_kind;
    assign dout.role            = r.role;
    assign dout.parameter_index = r.parameter_index;
    assign dout.payload_byte    = r.payload_byte;
    assign dout.header_code     = r.header_code;
    assign dout.command_code    = r.command_code;
    assign dout.status          = r.status;
    assign dout.last_result     = r.last_result;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

endmodule

>>> rtl/adc_message_parser.sv
`timescale 1ns / 1ps
// adc_message_parser: top level of the streaming ADC protocol message checker.
// Depends on adc_pkg, adc_if, adc_front, adc_queue, adc_back.

// Streaming ADC message parser. Feed one word per message byte on din; the word
// with end_of_message set closes the message and may carry no byte (has_byte = 0),
// which lets an empty message through. Header-token and parameter bytes come out
// on dout as payload words tagged by role (parameters already unescaped, index
// saturating at 255), and every message ends with one verdict word: valid, empty
// or invalid, with header and command codes on a valid verdict. Payload of an
// invalid message is still sent; the consumer drops it on the verdict. After the
// first syntax error the rest of the message produces no payload.
// Rate: the checker takes one word per cycle whenever the queue has room. A word
// yields zero, one or two results; the output register sends one result per cycle
// while dout.ready is high, so the queue (DEPTH entries) absorbs the extra results
// of closing bytes that also carry payload. No clearing pass after reset.
module adc_message_parser #(
    parameter int DEPTH = adc_pkg::QueueDepth
) (
    input  logic      clk,
    input  logic      rst_n,
    adc_in_if.sink    din,
    adc_out_if.source dout
);
    import adc_pkg::*;

    logic   q_push, q_full, q_pop, q_nonempty;
    entry_t q_in, q_head;

    // front: syntax check and classification of each byte
    adc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    // decoupling queue
    adc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head       (q_head)
    );

    // back: serializes payload and verdict words
    adc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .dout       (dout)
    );

endmodule

>>> test/adc_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from rtl/adc_if.sv.
// This file holds the stimulus word type shared by the testbench; depends on nothing.
package adc_tb_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       end_of_message;
    } in_word_t;

endpackage

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for adc_message_parser, with a streaming predictor.
// Depends on adc_pkg, adc_tb_pkg, adc_if and the parser RTL.
module testbench;
    import adc_pkg::*;
    import adc_tb_pkg::*;

    logic clk;
    logic rst_n;

    adc_in_if  din ();
    adc_out_if dout ();

    adc_message_parser dut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din.sink),
        .dout (dout.source)
    );

    // Parser state mirrored by the predictor
    phase_t      msg_phase;
    logic [7:0]  param_num;
    logic [2:0]  tok_chars;
    logic        esc_open;
    logic        tok_empty;
    logic [2:0]  hdr_letter;
    logic [23:0] cmd_letters;
    logic        msg_broken;

    in_word_t pending_words[$];
    result_t  expected_results[$];
    int       fail_count;

    // Command letter triples in code order
    logic [23:0] cmd_names[15] = '{
        "STA", "SUP", "SID", "INF", "MSG", "SCH", "RES", "CTM",
        "RCM", "QUI", "GPA", "PAS", "GET", "GFI", "SND"
    };

    function automatic logic [3:0] command_of(input logic [23:0] l);
        for (int i = 0; i < 15; i++)
        begin
            if (cmd_names[i] == l)
                return 4'(i);
        end
        return CMD_UNKNOWN;
    endfunction

    function automatic bit upper(input logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit alnum(input logic [7:0] c);
        return upper(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic bit base32(input logic [7:0] c);
        return upper(c) || (c >= "2" && c <= "7");
    endfunction

    function automatic bit no_tokens(input logic [2:0] h);
        return h == HDR_C || h == HDR_H || h == HDR_I;
    endfunction

    function automatic bit two_tokens(input logic [2:0] h);
        return h == HDR_D || h == HDR_E || h == HDR_F;
    endfunction

    task automatic clear_parse();
        msg_phase   = PH_HEAD;
        param_num   = '0;
        tok_chars   = '0;
        esc_open    = 1'b0;
        tok_empty   = 1'b0;
        hdr_letter  = '0;
        cmd_letters = '0;
        msg_broken  = 1'b0;
    endtask

    // Closing check for a non-empty token
    function automatic bit token_closes();
        if (msg_phase == PH_FIRST)
            return hdr_letter == HDR_U || tok_chars == 4;
        if (msg_phase == PH_SECOND)
            return hdr_letter == HDR_F ? tok_chars == 0 : tok_chars == 4;
        return !esc_open;
    endfunction

    task automatic push_payload(input logic [2:0] r, input logic [7:0] b);
        result_t x;
        x = '0;
        x.result_kind     = KIND_PAYLOAD;
        x.role            = r;
        x.parameter_index = (r == ROLE_PARAM) ? param_num : 8'd0;
        x.payload_byte    = b;
        x.header_code     = hdr_letter;
        x.command_code    = command_of(cmd_letters);
        expected_results.insert(expected_results.size(), x);
    endtask

    // One byte through the syntax checker; errors latch msg_broken
    task automatic parse_byte(input logic [7:0] b);
        logic [3:0] hc;
        bit         ok;
        if (msg_phase == PH_HEAD)
        begin
            if (tok_chars == 0)
            begin
                hc = head_code(b);
                ok = !hc[3];
                if (ok)
                    hdr_letter = hc[2:0];
            end
            else
            begin
                ok = (tok_chars == 1) ? upper(b) : alnum(b);
                cmd_letters = {cmd_letters[15:0], b};
            end
            if (!ok)
            begin
                msg_broken = 1'b1;
                return;
            end
            tok_chars++;
            if (tok_chars >= 4)
            begin
                msg_phase = PH_SPACE;
                tok_chars = 0;
            end
            return;
        end
        if (msg_phase == PH_SPACE)
        begin
            if (b != " ")
            begin
                msg_broken = 1'b1;
                return;
            end
            msg_phase = no_tokens(hdr_letter) ? PH_PARAM : PH_FIRST;
            tok_empty = 1'b1;
            tok_chars = 0;
            return;
        end
        if (b == " ")
        begin
            if (tok_empty || !token_closes())
            begin
                msg_broken = 1'b1;
                return;
            end
            if (msg_phase == PH_FIRST)
                msg_phase = two_tokens(hdr_letter) ? PH_SECOND : PH_PARAM;
            else if (msg_phase == PH_SECOND)
                msg_phase = PH_PARAM;
            else if (param_num != 8'd255)
                param_num++;
            tok_empty = 1'b1;
            tok_chars = 0;
            return;
        end
        tok_empty = 1'b0;
        if (msg_phase == PH_FIRST)
        begin
            if (!base32(b))
                msg_broken = 1'b1;
            else if (hdr_letter == HDR_U)
                push_payload(ROLE_SRC_CID, b);
            else if (tok_chars >= 4)
                msg_broken = 1'b1;
            else
            begin
                tok_chars++;
                push_payload(ROLE_SRC_SID, b);
            end
            return;
        end
        if (msg_phase == PH_SECOND)
        begin
            if (hdr_letter == HDR_F)
            begin
                ok = (tok_chars == 0) ? (b == "+" || b == "-")
                   : (tok_chars == 1) ? upper(b) : alnum(b);
                if (!ok)
                    msg_broken = 1'b1;
                else
                begin
                    tok_chars = (tok_chars >= 4) ? 3'd0 : tok_chars + 3'd1;
                    push_payload(ROLE_FEATURE, b);
                end
                return;
            end
            if (!base32(b) || tok_chars >= 4)
                msg_broken = 1'b1;
            else
            begin
                tok_chars++;
                push_payload(ROLE_TGT_SID, b);
            end
            return;
        end
        if (esc_open)
        begin
            esc_open = 1'b0;
            case (b)
                "s":     push_payload(ROLE_PARAM, " ");
                "n":     push_payload(ROLE_PARAM, 8'h0A);
                "\\":    push_payload(ROLE_PARAM, "\\");
                default: msg_broken = 1'b1;
            endcase
            return;
        end
        if (b == "\\")
            esc_open = 1'b1;
        else if (b == 8'h0A || b == 8'h0D)
            msg_broken = 1'b1;
        else
            push_payload(ROLE_PARAM, b);
    endtask

    function automatic logic [1:0] judge();
        if (!msg_broken && msg_phase == PH_HEAD && tok_chars == 0)
            return ST_EMPTY;
        if (msg_broken || msg_phase == PH_HEAD)
            return ST_INVALID;
        if (msg_phase == PH_SPACE)
            return no_tokens(hdr_letter) ? ST_VALID : ST_INVALID;
        if (tok_empty || !token_closes())
            return ST_INVALID;
        if (msg_phase == PH_FIRST && two_tokens(hdr_letter))
            return ST_INVALID;
        return ST_VALID;
    endfunction

    // Predict the results of one accepted word
    task automatic predict_word(input in_word_t w);
        result_t v;
        int      before_n;
        before_n = expected_results.size();
        if (w.has_byte && !msg_broken)
            parse_byte(w.byte_value);
        if (w.end_of_message)
        begin
            v = '0;
            v.result_kind  = KIND_VERDICT;
            v.status       = judge();
            v.header_code  = (v.status == ST_VALID) ? hdr_letter : 3'd0;
            v.command_code = (v.status == ST_VALID) ? command_of(cmd_letters) : CMD_UNKNOWN;
            expected_results.insert(expected_results.size(), v);
            clear_parse();
        end
        if (expected_results.size() > before_n)
            expected_results[$].last_result = 1'b1;
    endtask

    // Stimulus helpers
    task automatic put_byte(input logic [7:0] b, input bit eom);
        in_word_t w;
        w.byte_value = b;
        w.has_byte = 1'b1;
        w.end_of_message = eom;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic put_bare(input bit eom);
        in_word_t w;
        w.byte_value = 8'($urandom);
        w.has_byte = 1'b0;
        w.end_of_message = eom;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic put_text(input string s, input bit close_bare);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], !close_bare && i == s.len() - 1);
        if (close_bare)
            put_bare(1'b1);
    endtask

    function automatic logic [7:0] rand_b32();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range("2", "7"))
                                           : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] rand_an();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range("0", "9"))
                                           : 8'($urandom_range("A", "Z"));
    endfunction

    // Mostly well-formed messages, occasionally corrupted by one random byte
    function automatic string make_message();
        string hl;
        string s;
        int    n;
        int    np;
        hl = "BCDEFHIU";
        s = "";
        s = {s, string'(hl[$urandom_range(0, 7)])};
        if ($urandom_range(0, 4) != 0)
            s = {s, string'(cmd_names[$urandom_range(0, 14)])};
        else
            s = {s, string'(8'($urandom_range("A", "Z"))), string'(rand_an()),
                 string'(rand_an())};
        if (s[0] == "B" || s[0] == "D" || s[0] == "E" || s[0] == "F")
        begin
            s = {s, " "};
            for (int i = 0; i < 4; i++)
                s = {s, string'(rand_b32())};
        end
        if (s[0] == "D" || s[0] == "E")
        begin
            s = {s, " "};
            for (int i = 0; i < 4; i++)
                s = {s, string'(rand_b32())};
        end
        if (s[0] == "F")
        begin
            s = {s, " "};
            n = $urandom_range(1, 2);
            for (int g = 0; g < n; g++)
            begin
                s = {s, $urandom_range(0, 1) ? "+" : "-", string'(8'($urandom_range("A", "Z")))};
                for (int i = 0; i < 3; i++)
                    s = {s, string'(rand_an())};
            end
        end
        if (s[0] == "U")
        begin
            s = {s, " "};
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                s = {s, string'(rand_b32())};
        end
        np = $urandom_range(0, 3);
        for (int p = 0; p < np; p++)
        begin
            s = {s, " "};
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: s = {s, "\\s"};
                    1: s = {s, "\\n"};
                    2: s = {s, "\\\\"};
                    default: s = {s, string'(8'($urandom_range(8'h21, 8'hFF)))};
                endcase
            end
        end
        if ($urandom_range(0, 5) == 0)
            s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
        return s;
    endfunction

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: bursts of random length separated by random gaps
    int  burst_left;
    int  gap_left;
    bit  hold_off;

    initial
    begin
        din.valid = 1'b0;
        din.byte_value = '0;
        din.has_byte = 1'b0;
        din.end_of_message = 1'b0;
        burst_left = 0;
        gap_left = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din.valid && din.ready)
            begin
                predict_word('{din.byte_value, din.has_byte, din.end_of_message});
            end
            if (!(din.valid && !din.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    din.valid <= 1'b0;
                end
                else if (pending_words.size() != 0 && !hold_off)
                begin
                    {din.byte_value, din.has_byte, din.end_of_message}
                        <= pending_words.pop_front();
                    din.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    din.valid <= 1'b0;
            end
        end
    end

    // Monitor: receiver stalls in runs, with quiet periods of no stall
    int stall_phase;

    initial
    begin
        dout.ready = 1'b0;
        stall_phase = 0;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (dout.valid && dout.ready)
            begin
                got = '{dout.result_kind, dout.role, dout.parameter_index, dout.payload_byte,
                        dout.header_code, dout.command_code, dout.status, dout.last_result};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                dout.ready <= 1'b1;
            else
                dout.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial
    begin
        int nmsg;
        string msg;
        hold_off = 1'b0;
        fail_count = 0;
        clear_parse();

        // Directed: empty message, short ones, spacing, escapes, every header kind
        put_bare(1'b1);
        put_bare(1'b0);
        put_text("", 1'b1);
        put_text("HST", 1'b0);
        put_text("ISTA", 1'b0);
        put_text("CSTA ", 1'b1);
        put_text("ISUP  AB", 1'b0);
        put_text("XSTA", 1'b0);
        put_text("BINF AAAA", 1'b0);
        put_text("BMSG ABC2 ", 1'b0);
        put_text("DMSG AAAA BB77 hi", 1'b1);
        put_text("EMSG ZZZZ 2345", 1'b0);
        put_text("FSCH AAAA +TCP4-UDP9", 1'b0);
        put_text("FSCH AAAA +tcp4", 1'b0);
        put_text("UINF ZA234567 x", 1'b0);
        put_text("HSUP AD\\s\\n\\\\ B", 1'b0);
        put_text("IMSG a\\q", 1'b0);
        put_text("IMSG a\\", 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_text("ISND \xff\x01", 1'b0);
        put_text("IMSG a\rb", 1'b1);
        put_text("BSTA AAAAA", 1'b0);

        // Long message so the parameter index saturates
        msg = "IMSG";
        for (int i = 0; i < 270; i++)
            msg = {msg, " x"};
        put_text(msg, 1'b0);

        // Pause until the block has drained everything
        wait (pending_words.size() == 0);
        hold_off = 1'b1;
        wait (expected_results.size() == 0 && !din.valid);
        repeat (4) @(posedge clk);
        hold_off = 1'b0;

        // Random messages, with noise and split or bare endings mixed in
        nmsg = 0;
        while (nmsg < 55)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                begin
                    if ($urandom_range(0, 3) == 0)
                        put_bare(1'b0);
                    else
                        put_byte(8'($urandom), 1'b0);
                end
                put_bare(1'b1);
            end
            else
                put_text(make_message(), $urandom_range(0, 3) == 0);
            nmsg++;
            wait (pending_words.size() < 40);
        end

        wait (pending_words.size() == 0);
        wait (expected_results.size() == 0 && !din.valid);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASS adc_message_parser");
        else
            $display("FAIL adc_message_parser");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL adc_message_parser");
        $finish;
    end

endmodule
